### hw/rtl/trd_pkg.sv
package trd_pkg;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // framing characters
  localparam logic [7:0] CH_OPEN  = 8'h7b;  // '{'
  localparam logic [7:0] CH_CLOSE = 8'h7d;  // '}'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_COMMA = 8'h2c;  // ','
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_TAB   = 8'h09;  // first control white space
  localparam logic [7:0] CH_CR    = 8'h0d;  // last control white space
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // key name lengths
  localparam int unsigned TRACK_LEN = 5;
  localparam int unsigned SIDE_LEN  = 4;
  localparam int unsigned LENK_LEN  = 3;

  // candidate flag bits
  localparam int unsigned CAND_TRACK = 0;
  localparam int unsigned CAND_SIDE  = 1;
  localparam int unsigned CAND_LEN   = 2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       new_file;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] track_number;
    logic [7:0] side_number;
    logic       last_of_track;
  } out_t;

  function automatic logic [7:0] track_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h74;  // t
      3'd1:    ch = 8'h72;  // r
      3'd2:    ch = 8'h61;  // a
      3'd3:    ch = 8'h63;  // c
      3'd4:    ch = 8'h6b;  // k
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] side_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h73;  // s
      3'd1:    ch = 8'h69;  // i
      3'd2:    ch = 8'h64;  // d
      3'd3:    ch = 8'h65;  // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] len_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h6c;  // l
      3'd1:    ch = 8'h65;  // e
      3'd2:    ch = 8'h6e;  // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/track_record_deframer.sv
// channel | signals                      | direction | word
// --------+------------------------------+-----------+------------------------------
// input   | in_valid, in_ready, in_data  | in        | byte_value, new_file
// output  | out_valid, out_ready, out_data | out     | kind, data_byte, track_number,
//         |                              |           | side_number, last_of_track
//
// one input word per cycle while in_ready is high; its result (if any) appears in
// the output register the cycle after acceptance. the parser state and the output
// register update in the same edge, so throughput is set by the output register alone.
// rst (synchronous, active high) returns the parser to the intro state.
// when out_valid is high and out_ready low, in_ready drops until the word is taken.
module track_record_deframer
  import trd_pkg::*;
#(
  parameter int unsigned LEN_BITS      = 24,
  parameter int unsigned MAX_KEY_CHARS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned KPOS_W = $clog2(MAX_KEY_CHARS + 1);
  localparam int unsigned SUM_W  = LEN_BITS + 4;

  // parse modes
  localparam logic [2:0] MODE_INTRO = 3'd0;
  localparam logic [2:0] MODE_HEAD  = 3'd1;
  localparam logic [2:0] MODE_META  = 3'd2;
  localparam logic [2:0] MODE_KEY   = 3'd3;
  localparam logic [2:0] MODE_VAL   = 3'd4;
  localparam logic [2:0] MODE_BIN   = 3'd5;

  // value phase, kept in the key position register while in MODE_VAL
  localparam logic [KPOS_W-1:0] VPH_NONE = KPOS_W'(0);
  localparam logic [KPOS_W-1:0] VPH_POS  = KPOS_W'(1);
  localparam logic [KPOS_W-1:0] VPH_NEG  = KPOS_W'(2);

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic [2:0]          mode, mode_next;
  logic [KPOS_W-1:0]   kpos, kpos_next;
  logic [2:0]          cand, cand_next;
  logic [LEN_BITS-1:0] acc, acc_next;
  logic                stopped, stopped_next;
  logic [7:0]          track_reg, track_next;
  logic [7:0]          side_reg, side_next;
  logic [LEN_BITS-1:0] dlen, dlen_next;
  logic [LEN_BITS-1:0] count, count_next;
  logic                halted, halted_next;
  out_t                out_next;
  logic                emit;

  logic                accept;
  logic [7:0]          c;
  logic [2:0]          mode_eff;
  logic                halted_eff;
  logic                is_digit;
  logic                is_space;
  logic [2:0]          keep;
  logic [SUM_W-1:0]    sum;
  logic [LEN_BITS-1:0] acc_step;
  logic [LEN_BITS-1:0] value;
  logic [LEN_BITS-1:0] count_inc;

  // output register frees up when its word is taken
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign c          = in_data.byte_value;
  assign mode_eff   = in_data.new_file ? MODE_INTRO : mode;
  assign halted_eff = in_data.new_file ? 1'b0 : halted;
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // key candidates surviving this character
  always_comb begin
    keep = '0;
    keep[CAND_TRACK] = (kpos < KPOS_W'(TRACK_LEN)) && (c == track_char(kpos[2:0]));
    keep[CAND_SIDE]  = (kpos < KPOS_W'(SIDE_LEN))  && (c == side_char(kpos[2:0]));
    keep[CAND_LEN]   = (kpos < KPOS_W'(LENK_LEN))  && (c == len_char(kpos[2:0]));
  end

  // acc * 10 + digit, saturated
  assign sum      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + SUM_W'(c - CH_ZERO);
  assign acc_step = (sum[SUM_W-1:LEN_BITS] != '0) ? LEN_MAX : sum[LEN_BITS-1:0];

  assign value     = (kpos == VPH_NEG) ? '0 : acc;
  assign count_inc = count + LEN_BITS'(1);

  always_comb begin
    mode_next    = mode_eff;
    kpos_next    = in_data.new_file ? '0 : kpos;
    cand_next    = in_data.new_file ? 3'b111 : cand;
    acc_next     = in_data.new_file ? '0 : acc;
    stopped_next = in_data.new_file ? 1'b0 : stopped;
    dlen_next    = in_data.new_file ? '0 : dlen;
    count_next   = in_data.new_file ? '0 : count;
    halted_next  = halted_eff;
    track_next   = track_reg;
    side_next    = side_reg;
    emit         = 1'b0;
    out_next.kind          = KIND_PAYLOAD;
    out_next.data_byte     = c;
    out_next.track_number  = track_reg;
    out_next.side_number   = side_reg;
    out_next.last_of_track = 1'b0;

    if (!halted_eff) begin
      unique case (mode_eff)
        MODE_INTRO: begin
          if (c == CH_OPEN) mode_next = MODE_HEAD;
        end
        MODE_HEAD: begin
          if (c == CH_CLOSE) mode_next = MODE_META;
        end
        MODE_META: begin
          if (c == CH_OPEN) begin
            mode_next    = MODE_KEY;
            kpos_next    = '0;
            cand_next    = 3'b111;
            acc_next     = '0;
            stopped_next = 1'b0;
          end else begin
            // header brace missing: report once, then sit until new_file
            halted_next        = 1'b1;
            emit               = 1'b1;
            out_next.kind      = KIND_ERROR;
            out_next.data_byte = 8'h00;
          end
        end
        MODE_KEY: begin
          if (c == CH_COLON) begin
            cand_next[CAND_TRACK] = cand[CAND_TRACK] && (kpos == KPOS_W'(TRACK_LEN));
            cand_next[CAND_SIDE]  = cand[CAND_SIDE]  && (kpos == KPOS_W'(SIDE_LEN));
            cand_next[CAND_LEN]   = cand[CAND_LEN]   && (kpos == KPOS_W'(LENK_LEN));
            kpos_next    = VPH_NONE;
            acc_next     = '0;
            stopped_next = 1'b0;
            mode_next    = MODE_VAL;
          end else if (kpos >= KPOS_W'(MAX_KEY_CHARS)) begin
            cand_next = '0;
          end else begin
            cand_next = cand & keep;
            kpos_next = kpos + KPOS_W'(1);
          end
        end
        MODE_VAL: begin
          if (c == CH_COMMA || c == CH_CLOSE) begin
            if (cand[CAND_TRACK])
              track_next = (value > LEN_BITS'(255)) ? 8'hff : value[7:0];
            if (cand[CAND_SIDE])
              side_next = (value > LEN_BITS'(255)) ? 8'hff : value[7:0];
            if (cand[CAND_LEN])
              dlen_next = value;
            kpos_next    = '0;
            cand_next    = 3'b111;
            acc_next     = '0;
            stopped_next = 1'b0;
            if (c == CH_CLOSE) begin
              mode_next  = MODE_BIN;
              count_next = '0;
            end else begin
              mode_next = MODE_KEY;
            end
          end else if (!stopped) begin
            // atoi: leading white space, optional sign, digits
            priority if (kpos == VPH_NONE && is_space) begin
              kpos_next = kpos;
            end else if (kpos == VPH_NONE && c == CH_PLUS) begin
              kpos_next = VPH_POS;
            end else if (kpos == VPH_NONE && c == CH_MINUS) begin
              kpos_next = VPH_NEG;
            end else if (!is_digit) begin
              stopped_next = 1'b1;
            end else begin
              if (kpos == VPH_NONE) kpos_next = VPH_POS;
              acc_next = acc_step;
            end
          end
        end
        MODE_BIN: begin
          if (count >= dlen) begin
            // payload done: wait for the next header
            if (c == CH_OPEN) begin
              mode_next    = MODE_KEY;
              kpos_next    = '0;
              cand_next    = 3'b111;
              acc_next     = '0;
              stopped_next = 1'b0;
            end
          end else begin
            count_next             = count_inc;
            emit                   = 1'b1;
            out_next.last_of_track = (count_inc == dlen);
          end
        end
        default: begin
          mode_next = MODE_INTRO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_INTRO;
      kpos      <= '0;
      cand      <= 3'b111;
      acc       <= '0;
      stopped   <= 1'b0;
      track_reg <= '0;
      side_reg  <= '0;
      dlen      <= '0;
      count     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        kpos      <= kpos_next;
        cand      <= cand_next;
        acc       <= acc_next;
        stopped   <= stopped_next;
        track_reg <= track_next;
        side_reg  <= side_next;
        dlen      <= dlen_next;
        count     <= count_next;
        halted    <= halted_next;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a word is emitted
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= out_next;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import trd_pkg::*;

  localparam int unsigned LEN_W   = 24;
  localparam int unsigned KEY_MAX = 8;
  localparam logic [63:0] LEN_SAT = (64'd1 << LEN_W) - 64'd1;

  localparam int RAND_ITEMS  = 1500;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PAY_CAP     = 48;    // most payload bytes sent per track
  localparam int DRAIN_EVERY = 400;
  localparam longint LIMIT_NS = 64'd3600000;

  // value sign phase, kept in the key position counter while a value is parsed
  localparam int unsigned SGN_NONE = 0;
  localparam int unsigned SGN_POS  = 1;
  localparam int unsigned SGN_NEG  = 2;

  localparam logic [39:0] NAME_TRACK = "track";
  localparam logic [39:0] NAME_SIDE  = "side";
  localparam logic [39:0] NAME_LEN   = "len";

  typedef enum logic [2:0] {
    PM_INTRO, PM_DISK_HDR, PM_BRACE, PM_KEY, PM_VALUE, PM_PAYLOAD
  } pmode_e;

  // directed stimulus row; pin marks a row whose word is typed in here
  typedef struct packed {
    logic [7:0] b;
    logic       nf;
    logic       pin;
    out_t       res;
  } plan_row_t;

  localparam out_t NO_WORD = '0;

  localparam plan_row_t PLAN [29] = '{
    '{CH_OPEN,  1'b1, 1'b0, NO_WORD},   // new file, intro ends at once
    '{CH_CLOSE, 1'b0, 1'b0, NO_WORD},   // empty disk header
    // header brace missing: error word with reset track and side
    '{8'h00,    1'b0, 1'b1, '{KIND_ERROR, 8'h00, 8'h00, 8'h00, 1'b0}},
    '{CH_OPEN,  1'b0, 1'b0, NO_WORD},   // halted, ignored
    '{CH_OPEN,  1'b1, 1'b0, NO_WORD},   // new file clears the halt
    '{CH_CLOSE, 1'b0, 1'b0, NO_WORD},
    '{CH_OPEN,  1'b0, 1'b0, NO_WORD},   // track header opens
    '{"l",      1'b0, 1'b0, NO_WORD},
    '{"e",      1'b0, 1'b0, NO_WORD},
    '{"n",      1'b0, 1'b0, NO_WORD},
    '{CH_COLON, 1'b0, 1'b0, NO_WORD},
    '{"2",      1'b0, 1'b0, NO_WORD},
    '{CH_CLOSE, 1'b0, 1'b0, NO_WORD},   // len 2
    '{8'hff,    1'b0, 1'b1, '{KIND_PAYLOAD, 8'hff, 8'h00, 8'h00, 1'b0}},
    '{8'h00,    1'b0, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{8'h55,    1'b0, 1'b0, NO_WORD},   // past the payload, ignored
    '{CH_OPEN,  1'b0, 1'b0, NO_WORD},   // next header
    '{"t",      1'b0, 1'b0, NO_WORD},
    '{"r",      1'b0, 1'b0, NO_WORD},
    '{"a",      1'b0, 1'b0, NO_WORD},
    '{"c",      1'b0, 1'b0, NO_WORD},
    '{"k",      1'b0, 1'b0, NO_WORD},
    '{CH_COLON, 1'b0, 1'b0, NO_WORD},
    '{"9",      1'b0, 1'b0, NO_WORD},
    '{"9",      1'b0, 1'b0, NO_WORD},
    '{"9",      1'b0, 1'b0, NO_WORD},
    '{CH_CLOSE, 1'b0, 1'b0, NO_WORD},   // track saturates, len still 2
    '{8'h80,    1'b0, 1'b1, '{KIND_PAYLOAD, 8'h80, 8'hff, 8'h00, 1'b0}},
    '{8'h7f,    1'b0, 1'b1, '{KIND_PAYLOAD, 8'h7f, 8'hff, 8'h00, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // parser copy used to predict the output words
  pmode_e      pm;
  int unsigned kpos;
  logic [2:0]  cand;
  logic [63:0] acc;
  logic        stopped;
  logic [7:0]  trk;
  logic [7:0]  sid;
  logic [63:0] dlen;
  logic [63:0] bcnt;
  logic        halt;

  out_t words_due [$];   // predicted words not yet seen at the output
  int   burst_left = 0;
  int   sent = 0;
  int   errors = 0;
  bit   hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  track_record_deframer #(
    .LEN_BITS      (LEN_W),
    .MAX_KEY_CHARS (KEY_MAX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------- parser copy

  function automatic void parser_new_key();
    kpos    = 0;
    cand    = 3'b111;
    acc     = '0;
    stopped = 1'b0;
  endfunction

  // everything but track and side goes back to reset
  function automatic void parser_restart();
    pm = PM_INTRO;
    parser_new_key();
    dlen = '0;
    bcnt = '0;
    halt = 1'b0;
  endfunction

  // character i of a key name that is n characters long
  function automatic logic [7:0] name_at(input logic [39:0] nm, input int unsigned n,
                                         input int unsigned i);
    return nm[8*(n-1-i) +: 8];
  endfunction

  function automatic void parser_key_char(input logic [7:0] c);
    logic [2:0] keep;
    keep = '0;
    // too long for any name: nothing can match any more
    if (kpos >= KEY_MAX) begin
      cand = '0;
      return;
    end
    if (kpos < TRACK_LEN && c == name_at(NAME_TRACK, TRACK_LEN, kpos)) keep[CAND_TRACK] = 1'b1;
    if (kpos < SIDE_LEN && c == name_at(NAME_SIDE, SIDE_LEN, kpos)) keep[CAND_SIDE] = 1'b1;
    if (kpos < LENK_LEN && c == name_at(NAME_LEN, LENK_LEN, kpos)) keep[CAND_LEN] = 1'b1;
    cand &= keep;
    kpos++;
  endfunction

  // the colon: only a name of exactly the right length survives
  function automatic void parser_key_done();
    logic [2:0] keep;
    keep = '0;
    if (kpos == TRACK_LEN) keep[CAND_TRACK] = 1'b1;
    if (kpos == SIDE_LEN) keep[CAND_SIDE] = 1'b1;
    if (kpos == LENK_LEN) keep[CAND_LEN] = 1'b1;
    cand   &= keep;
    kpos    = SGN_NONE;
    acc     = '0;
    stopped = 1'b0;
  endfunction

  // decimal parse with leading white space and optional sign
  function automatic void parser_value_char(input logic [7:0] c);
    logic digit;
    digit = (c >= CH_ZERO && c <= CH_NINE);
    if (stopped) return;
    if (kpos == SGN_NONE) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_PLUS) begin
        kpos = SGN_POS;
        return;
      end
      if (c == CH_MINUS) begin
        kpos = SGN_NEG;
        return;
      end
      if (!digit) begin
        stopped = 1'b1;
        return;
      end
      kpos = SGN_POS;
    end
    if (!digit) begin
      stopped = 1'b1;
      return;
    end
    acc = acc * 64'd10 + 64'(c - CH_ZERO);
    if (acc > LEN_SAT) acc = LEN_SAT;
  endfunction

  function automatic void parser_value_done();
    logic [63:0] v;
    v = (kpos == SGN_NEG) ? 64'd0 : acc;
    if (cand[CAND_TRACK]) trk = (v > 64'd255) ? 8'hff : v[7:0];
    if (cand[CAND_SIDE]) sid = (v > 64'd255) ? 8'hff : v[7:0];
    if (cand[CAND_LEN]) dlen = v;
  endfunction

  // one accepted input word; returns 1 when it yields an output word
  function automatic bit parser_step(input in_t w, output out_t r);
    logic [7:0] c;
    c = w.byte_value;
    r = '0;
    if (w.new_file) parser_restart();
    if (halt) return 1'b0;
    case (pm)
      PM_INTRO: begin
        if (c == CH_OPEN) pm = PM_DISK_HDR;
      end
      PM_DISK_HDR: begin
        if (c == CH_CLOSE) pm = PM_BRACE;
      end
      PM_BRACE: begin
        if (c == CH_OPEN) begin
          pm = PM_KEY;
          parser_new_key();
        end else begin
          // missing header brace: one error word, then halt until a new file
          halt           = 1'b1;
          r.kind         = KIND_ERROR;
          r.track_number = trk;
          r.side_number  = sid;
          return 1'b1;
        end
      end
      PM_KEY: begin
        if (c == CH_COLON) begin
          parser_key_done();
          pm = PM_VALUE;
        end else begin
          parser_key_char(c);
        end
      end
      PM_VALUE: begin
        if (c == CH_COMMA || c == CH_CLOSE) begin
          parser_value_done();
          parser_new_key();
          if (c == CH_CLOSE) begin
            pm   = PM_PAYLOAD;
            bcnt = '0;
          end else begin
            pm = PM_KEY;
          end
        end else begin
          parser_value_char(c);
        end
      end
      PM_PAYLOAD: begin
        if (bcnt >= dlen) begin
          if (c == CH_OPEN) begin
            pm = PM_KEY;
            parser_new_key();
          end
        end else begin
          bcnt++;
          r.kind          = KIND_PAYLOAD;
          r.data_byte     = c;
          r.track_number  = trk;
          r.side_number   = sid;
          r.last_of_track = (bcnt == dlen);
          return 1'b1;
        end
      end
      default: pm = PM_INTRO;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_bad(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // every output word taken is compared with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        report_bad("word with nothing expected", 32'(out_data), 32'd0);
      end else begin
        want = words_due.pop_front();
        if (out_data.kind !== want.kind)
          report_bad("kind", 32'(out_data.kind), 32'(want.kind));
        if (out_data.data_byte !== want.data_byte)
          report_bad("data_byte", 32'(out_data.data_byte), 32'(want.data_byte));
        if (out_data.track_number !== want.track_number)
          report_bad("track_number", 32'(out_data.track_number), 32'(want.track_number));
        if (out_data.side_number !== want.side_number)
          report_bad("side_number", 32'(out_data.side_number), 32'(want.side_number));
        if (out_data.last_of_track !== want.last_of_track)
          report_bad("last_of_track", 32'(out_data.last_of_track), 32'(want.last_of_track));
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // offer one word; bursts of random length with random gaps between them.
  // valid is only lowered where a real gap follows, so it never drops and
  // rises in the same step
  task automatic send_word(input in_t w, input bit pin, input out_t pinned);
    out_t r;
    bit   has;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: advance the parser copy
    has = parser_step(w, r);
    if (pin) words_due.push_back(pinned);
    else if (has) words_due.push_back(r);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic nf);
    in_t w;
    w.byte_value = b;
    w.new_file   = nf;
    send_word(w, 1'b0, NO_WORD);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_except(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  // sender stops until every predicted word has come out
  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stream pieces

  // mostly small numbers so that payloads stay short
  task automatic send_number();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) send_text($sformatf("%0d", $urandom_range(0, 9)));
    else if (pick < 9) send_text($sformatf("%0d", $urandom_range(10, 40)));
    else send_text($sformatf("%0d", $urandom_range(0, 70000)));
  endtask

  task automatic send_value();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_number();
    end else if (pick < 60) begin
      // leading white space, space or a control character
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) send_byte(CH_SPACE, 1'b0);
        else send_byte(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
      end
      send_number();
    end else if (pick < 68) begin
      send_byte(CH_PLUS, 1'b0);
      send_number();
    end else if (pick < 76) begin
      send_byte(CH_MINUS, 1'b0);   // negative stores zero
      send_number();
    end else if (pick < 82) begin
      // no digits at all
    end else if (pick < 88) begin
      // digits stop at the first non-digit
      send_number();
      send_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
      send_number();
    end else if (pick < 91) begin
      send_text("+-3");
    end else if (pick < 94) begin
      send_text("99999999999");   // saturates
    end else begin
      do n = $urandom_range(0, 255); while (n == CH_COMMA || n == CH_CLOSE);
      send_byte(8'(n), 1'b0);
      send_number();
    end
  endtask

  task automatic send_key();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 30) send_text("track");
    else if (pick < 55) send_text("side");
    else if (pick < 80) send_text("len");
    else if (pick < 84) send_text("trackname");   // longer than any name allows
    else if (pick < 87) send_text("tra");
    else if (pick < 90) send_text("lenx");
    else if (pick < 93) send_text("sidesid");
    else if (pick < 97) begin
      // comma, brace and zero are plain key characters
      send_byte(CH_COMMA, 1'b0);
      send_byte(CH_CLOSE, 1'b0);
      send_byte(8'h00, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_byte(rand_except(CH_COLON), 1'b0);
    end
    // otherwise an empty key
  endtask

  // one track header and its payload; a forced length goes in as the last pair
  task automatic gen_track(input int force_len);
    int pairs;
    int n;
    send_byte(CH_OPEN, 1'b0);
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      if (p == pairs - 1 && force_len >= 0) begin
        send_text($sformatf("len:%0d", force_len));
      end else begin
        send_key();
        send_byte(CH_COLON, 1'b0);
        send_value();
      end
      send_byte((p == pairs - 1) ? CH_CLOSE : CH_COMMA, 1'b0);
    end
    n = 0;
    while (pm == PM_PAYLOAD && bcnt < dlen && n < PAY_CAP) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      n++;
    end
  endtask

  // a whole image: intro, disk header, then a few tracks
  task automatic gen_file();
    int n;
    int tracks;
    send_byte(rand_except(CH_OPEN), 1'b1);
    n = $urandom_range(0, 4);
    repeat (n) send_byte(rand_except(CH_OPEN), 1'b0);
    send_byte(CH_OPEN, 1'b0);
    n = $urandom_range(0, 5);
    repeat (n) send_byte(rand_except(CH_CLOSE), 1'b0);
    send_byte(CH_CLOSE, 1'b0);
    // broken image: the track header brace is missing
    if ($urandom_range(0, 99) < 8) begin
      send_byte(rand_except(CH_OPEN), 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    tracks = $urandom_range(1, 5);
    repeat (tracks) begin
      gen_track(-1);
      // length too large to finish here; the next image restarts the parser
      if (pm == PM_PAYLOAD && bcnt < dlen) return;
      n = $urandom_range(0, 2);
      repeat (n) send_byte(rand_except(CH_OPEN), 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(5, 30);
    repeat (n) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
  endtask

  // ---------------------------------------------------------------- receiver

  // runs of one stall style at a time; a hold-off request wins
  initial begin
    int run_left;
    int style;
    run_left  = 0;
    style     = 0;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          style    = $urandom_range(0, 3);
        end
        run_left--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    in_t w;
    int  first_rand;
    int  files;
    int  last_drain;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    parser_restart();
    trk = '0;
    sid = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < $size(PLAN); i++) begin
      w.byte_value = PLAN[i].b;
      w.new_file   = PLAN[i].nf;
      send_word(w, PLAN[i].pin, PLAN[i].res);
    end
    wait_drained();

    // random images, with noise now and then
    first_rand = sent;
    last_drain = sent;
    files      = 0;
    while (sent - first_rand < RAND_ITEMS) begin
      files++;
      if (files == 3) begin
        // receiver holds off while a long payload keeps coming
        send_byte(CH_OPEN, 1'b1);
        send_byte(CH_CLOSE, 1'b0);
        hold_req = 1'b1;
        gen_track(40);
      end else if ($urandom_range(0, 99) < 6) begin
        send_noise();
      end else begin
        gen_file();
      end
      if (sent - last_drain > DRAIN_EVERY) begin
        wait_drained();
        last_drain = sent;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/trd_pkg.sv
hw/rtl/track_record_deframer.sv
tb/tb_top.sv
